// ===== sv/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the escape-time engine
// Word formats, configuration record, unit request/response records and the
// sequencer state type.
// ----------------------------------------------------------------------------
package met_pkg;

  // fixed word widths
  localparam int WORD_W    = 32;            // signed fixed-point word
  localparam int RECIP_W   = 31;            // unsigned reciprocal / ratio
  localparam int CNT_W     = 16;            // iteration count, shade, max_iter
  localparam int MUL_W     = WORD_W + 1;    // multiplier operand, signed
  localparam int ACC_W     = 2 * MUL_W;     // full product / wide sums
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = $clog2(CNT_W + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM_SCALE  = 3'd0,
    REG_OFFSET_REAL = 3'd1,
    REG_OFFSET_IMAG = 3'd2,
    REG_INV_WIDTH   = 3'd3,
    REG_INV_HEIGHT  = 3'd4,
    REG_ASPECT      = 3'd5,
    REG_MAX_ITER    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0]  zoom_scale;
    logic [WORD_W-1:0]  offset_real;
    logic [WORD_W-1:0]  offset_imag;
    logic [RECIP_W-1:0] inv_width;
    logic [RECIP_W-1:0] inv_height;
    logic [RECIP_W-1:0] aspect;
    logic [CNT_W-1:0]   max_iter;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zoom_scale:  32'h1000_0000,
    offset_real: 32'h0000_0000,
    offset_imag: 32'h0000_0000,
    inv_width:   31'h0004_0000,
    inv_height:  31'h0004_0000,
    aspect:      31'h1000_0000,
    max_iter:    16'd256
  };

  // request to the shared multiplier
  typedef struct packed {
    logic             shift;   // rescale product by the fraction bits
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

  // shade divider handshake
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MX_MUL,
    ST_MX_CHK,
    ST_MA_MUL,
    ST_MA_CHK,
    ST_MX_CTR,
    ST_MZX_MUL,
    ST_MZX_CHK,
    ST_MY_MUL,
    ST_MY_CHK,
    ST_MY_CTR,
    ST_MZY_MUL,
    ST_MZY_CHK,
    ST_SQ_R,
    ST_SQ_I,
    ST_SQ_CHK,
    ST_LOOP,
    ST_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } seq_state_t;

  // value lies in the signed word range
  function automatic logic fits_word(acc_t v);
    logic [ACC_W-WORD_W:0] hi;
    hi = v[ACC_W-1:WORD_W-1];
    return (&hi) | ~(|hi);
  endfunction

  // sign-extend a word to the wide sum format
  function automatic acc_t word_ext(word_t w);
    return acc_t'(w);
  endfunction

  // word as a multiplier operand
  function automatic logic [MUL_W-1:0] mul_word(word_t w);
    return {w[WORD_W-1], w};
  endfunction

  // unsigned reciprocal as a multiplier operand
  function automatic logic [MUL_W-1:0] mul_recip(logic [RECIP_W-1:0] r);
    return {{(MUL_W-RECIP_W){1'b0}}, r};
  endfunction

endpackage

// ===== sv/met_stream_if.sv =====
// ----------------------------------------------------------------------------
// met_stream_if: pixel and result channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface met_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface met_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [15:0]           escape_count;
  logic [15:0]           shade;

  modport source (output valid, output out_x, output out_y, output escape_count,
                  output shade, input ready);
  modport sink   (input valid, input out_x, input out_y, input escape_count,
                  input shade, output ready);
endinterface

// ===== sv/met_mul.sv =====
// ----------------------------------------------------------------------------
// met_mul: shared signed multiplier
// One signed product per cycle, optionally rescaled by the fraction bits
// (arithmetic shift, rounds toward minus infinity), result registered.
// ----------------------------------------------------------------------------
module met_mul #(
  parameter int FRAC_BITS = 28
) (
  input  logic              clk,
  input  met_pkg::mul_req_t req,
  output met_pkg::acc_t     prod
);

  met_pkg::acc_t raw;
  met_pkg::acc_t prod_r;

  // full-width signed product
  assign raw = $signed(req.op_a) * $signed(req.op_b);

  // product register
  always_ff @(posedge clk) begin
    prod_r <= req.shift ? (raw >>> FRAC_BITS) : raw;
  end

  assign prod = prod_r;

endmodule

// ===== sv/met_div.sv =====
// ----------------------------------------------------------------------------
// met_div: shade divider
// Restoring division, one quotient bit a cycle: (dividend << 16) / divisor,
// for a dividend below the divisor. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module met_div (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::div_req_t req,
  output met_pkg::div_rsp_t rsp
);

  localparam int CW = met_pkg::CNT_W;
  localparam int SW = met_pkg::STEP_W;

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [CW-1:0] rem_r;
  logic [CW-1:0] rem_nxt;
  logic [CW-1:0] quo_r;
  logic [CW-1:0] quo_nxt;
  logic [CW-1:0] div_r;
  logic [CW:0]   dbl;
  logic [CW:0]   diff;
  logic          ge;

  // one restoring step
  always_comb begin
    dbl     = {rem_r, 1'b0};
    diff    = dbl - {1'b0, div_r};
    ge      = dbl >= {1'b0, div_r};
    rem_nxt = ge ? diff[CW-1:0] : dbl[CW-1:0];
    quo_nxt = {quo_r[CW-2:0], ge};
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= SW'(CW);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      quo_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = (div_r == '0) ? '0 : quo_r;

endmodule

// ===== sv/met_seq.sv =====
// ----------------------------------------------------------------------------
// met_seq: escape-time sequencer
// Maps the pixel to c, runs z = z^2 + c through the shared multiplier, counts
// steps, starts the shade division and holds the result word.
// ----------------------------------------------------------------------------
module met_seq #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  met_in_if.sink            in_pix,
  met_out_if.source         out_res,
  input  met_pkg::cfg_t     cfg,
  output met_pkg::mul_req_t mul_req,
  input  met_pkg::acc_t     prod,
  output met_pkg::div_req_t div_req,
  input  met_pkg::div_rsp_t div_rsp
);

  localparam int CW = met_pkg::CNT_W;
  localparam int MW = met_pkg::MUL_W;
  localparam int WW = met_pkg::WORD_W;

  // half in the fixed-point format, and the bailout radius squared
  localparam met_pkg::acc_t CENTER = met_pkg::acc_t'(1) <<< (FRAC_BITS - 1);
  localparam met_pkg::acc_t LIMIT  = met_pkg::acc_t'(4) <<< FRAC_BITS;

  met_pkg::seq_state_t   state_r, state_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic [COORD_BITS-1:0] py_r, py_nxt;
  met_pkg::word_t        t_r, t_nxt;
  met_pkg::word_t        cr_r, cr_nxt;
  met_pkg::word_t        ci_r, ci_nxt;
  met_pkg::word_t        zr_r, zr_nxt;
  met_pkg::word_t        zi_r, zi_nxt;
  met_pkg::acc_t         rr_r, rr_nxt;
  met_pkg::acc_t         ii_r, ii_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  init_r, init_nxt;
  met_pkg::acc_t         sum_a;
  met_pkg::acc_t         sum_b;
  logic                  load_out;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [CW-1:0]         out_count_r;
  logic [CW-1:0]         out_shade_r;

  // next state and unit control
  always_comb begin
    state_nxt = state_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    t_nxt     = t_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    rr_nxt    = rr_r;
    ii_nxt    = ii_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    init_nxt  = init_r;
    sum_a     = '0;
    sum_b     = '0;
    load_out  = 1'b0;
    in_pix.ready     = 1'b0;
    mul_req          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = count_r;
    div_req.divisor  = cfg.max_iter;

    case (state_r)
      met_pkg::ST_IDLE: begin
        in_pix.ready = 1'b1;
        if (in_pix.valid) begin
          px_nxt    = in_pix.pixel_x;
          py_nxt    = in_pix.pixel_y;
          cnt_nxt   = '0;
          state_nxt = met_pkg::ST_MX_MUL;
        end
      end

      // real axis: x * inv_width, * aspect, - 0.5, * zoom + offset
      met_pkg::ST_MX_MUL: begin
        mul_req.op_a = {{(MW-COORD_BITS){1'b0}}, px_r};
        mul_req.op_b = met_pkg::mul_recip(cfg.inv_width);
        state_nxt    = met_pkg::ST_MX_CHK;
      end
      met_pkg::ST_MX_CHK: begin
        sum_a = prod;
        t_nxt = sum_a[WW-1:0];
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_MA_MUL : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end
      met_pkg::ST_MA_MUL: begin
        mul_req.shift = 1'b1;
        mul_req.op_a  = met_pkg::mul_word(t_r);
        mul_req.op_b  = met_pkg::mul_recip(cfg.aspect);
        state_nxt     = met_pkg::ST_MA_CHK;
      end
      met_pkg::ST_MA_CHK: begin
        sum_a = prod;
        t_nxt = sum_a[WW-1:0];
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_MX_CTR : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end
      met_pkg::ST_MX_CTR: begin
        sum_a = met_pkg::word_ext(t_r) - CENTER;
        t_nxt = sum_a[WW-1:0];
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_MZX_MUL : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end
      met_pkg::ST_MZX_MUL: begin
        mul_req.shift = 1'b1;
        mul_req.op_a  = met_pkg::mul_word(t_r);
        mul_req.op_b  = met_pkg::mul_word(cfg.zoom_scale);
        state_nxt     = met_pkg::ST_MZX_CHK;
      end
      met_pkg::ST_MZX_CHK: begin
        sum_a  = prod + met_pkg::word_ext(cfg.offset_real);
        cr_nxt = sum_a[WW-1:0];
        zr_nxt = sum_a[WW-1:0];
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_MY_MUL : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end

      // imaginary axis: y * inv_height, - 0.5, * zoom + offset
      met_pkg::ST_MY_MUL: begin
        mul_req.op_a = {{(MW-COORD_BITS){1'b0}}, py_r};
        mul_req.op_b = met_pkg::mul_recip(cfg.inv_height);
        state_nxt    = met_pkg::ST_MY_CHK;
      end
      met_pkg::ST_MY_CHK: begin
        sum_a = prod;
        t_nxt = sum_a[WW-1:0];
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_MY_CTR : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end
      met_pkg::ST_MY_CTR: begin
        sum_a = met_pkg::word_ext(t_r) - CENTER;
        t_nxt = sum_a[WW-1:0];
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_MZY_MUL : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end
      met_pkg::ST_MZY_MUL: begin
        mul_req.shift = 1'b1;
        mul_req.op_a  = met_pkg::mul_word(t_r);
        mul_req.op_b  = met_pkg::mul_word(cfg.zoom_scale);
        state_nxt     = met_pkg::ST_MZY_CHK;
      end
      met_pkg::ST_MZY_CHK: begin
        sum_a    = prod + met_pkg::word_ext(cfg.offset_imag);
        ci_nxt   = sum_a[WW-1:0];
        zi_nxt   = sum_a[WW-1:0];
        init_nxt = 1'b1;
        state_nxt = met_pkg::fits_word(sum_a) ? met_pkg::ST_SQ_R : met_pkg::ST_DIV_GO;
        count_nxt = '0;
      end

      // squares of z; also the bailout test after an update
      met_pkg::ST_SQ_R: begin
        mul_req.shift = 1'b1;
        mul_req.op_a  = met_pkg::mul_word(zr_r);
        mul_req.op_b  = met_pkg::mul_word(zr_r);
        state_nxt     = met_pkg::ST_SQ_I;
      end
      met_pkg::ST_SQ_I: begin
        mul_req.shift = 1'b1;
        mul_req.op_a  = met_pkg::mul_word(zi_r);
        mul_req.op_b  = met_pkg::mul_word(zi_r);
        rr_nxt        = prod;
        state_nxt     = met_pkg::ST_SQ_CHK;
      end
      met_pkg::ST_SQ_CHK: begin
        ii_nxt = prod;
        sum_a  = rr_r + prod;
        if (!init_r && (sum_a > LIMIT)) begin
          count_nxt = cnt_r;
          state_nxt = met_pkg::ST_DIV_GO;
        end else begin
          if (!init_r) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          init_nxt  = 1'b0;
          state_nxt = met_pkg::ST_LOOP;
        end
      end

      // loop head: limit check, cross term
      met_pkg::ST_LOOP: begin
        if (cnt_r == cfg.max_iter) begin
          count_nxt = '0;
          state_nxt = met_pkg::ST_DIV_GO;
        end else begin
          mul_req.shift = 1'b1;
          mul_req.op_a  = met_pkg::mul_word(zr_r);
          mul_req.op_b  = met_pkg::mul_word(zi_r);
          state_nxt     = met_pkg::ST_UPD;
        end
      end
      // z = z^2 + c; overflow counts as escape
      met_pkg::ST_UPD: begin
        sum_a  = rr_r - ii_r + met_pkg::word_ext(cr_r);
        sum_b  = (prod <<< 1) + met_pkg::word_ext(ci_r);
        zr_nxt = sum_a[WW-1:0];
        zi_nxt = sum_b[WW-1:0];
        if (met_pkg::fits_word(sum_a) && met_pkg::fits_word(sum_b)) begin
          state_nxt = met_pkg::ST_SQ_R;
        end else begin
          count_nxt = cnt_r;
          state_nxt = met_pkg::ST_DIV_GO;
        end
      end

      // shade = (count << 16) / max_iter
      met_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = met_pkg::ST_DIV_WAIT;
      end
      met_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = met_pkg::ST_EMIT;
        end
      end
      met_pkg::ST_EMIT: begin
        if (!out_valid_r || out_res.ready) begin
          load_out  = 1'b1;
          state_nxt = met_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = met_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= met_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    t_r     <= t_nxt;
    cr_r    <= cr_nxt;
    ci_r    <= ci_nxt;
    zr_r    <= zr_nxt;
    zi_r    <= zi_nxt;
    rr_r    <= rr_nxt;
    ii_r    <= ii_nxt;
    cnt_r   <= cnt_nxt;
    count_r <= count_nxt;
    init_r  <= init_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r     <= px_r;
      out_y_r     <= py_r;
      out_count_r <= count_r;
      out_shade_r <= div_rsp.quotient;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.out_x        = out_x_r;
  assign out_res.out_y        = out_y_r;
  assign out_res.escape_count = out_count_r;
  assign out_res.shade        = out_shade_r;

endmodule

// ===== sv/mandelbrot_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top: escape-time pixel engine
// Takes one pixel word (pixel_x, pixel_y) on in_pix and returns one result
// word (out_x, out_y, escape_count, shade) on out_res, both valid/ready.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata,
// one register per cycle. The user must write them only while the engine
// is idle; the block itself does not enforce this. Flow: the engine forms
// c, takes the squares of c, then runs each iteration through the one
// shared multiplier; it ends with the shade division and a load of the
// result register. A pixel that overflows while forming c goes straight
// to the shade division. The multiplier sets the iteration time: three
// products per step, one issued per cycle.
// One pixel is in flight at a time; in_pix.ready is high only when idle.
// The result sits in an output register, so a stalled receiver does not stop
// the next pixel from being accepted; only a second result waits for it.
// Reset (synchronous, active low) empties the engine and the output
// register and loads the register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  met_in_if.sink                            in_pix,
  met_out_if.source                         out_res,
  input  logic                              cfg_we,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [met_pkg::WORD_W-1:0]        cfg_wdata
);

  met_pkg::cfg_t     cfg_r;
  met_pkg::mul_req_t mul_req;
  met_pkg::acc_t     prod;
  met_pkg::div_req_t div_req;
  met_pkg::div_rsp_t div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= met_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        met_pkg::REG_ZOOM_SCALE:  cfg_r.zoom_scale  <= cfg_wdata;
        met_pkg::REG_OFFSET_REAL: cfg_r.offset_real <= cfg_wdata;
        met_pkg::REG_OFFSET_IMAG: cfg_r.offset_imag <= cfg_wdata;
        met_pkg::REG_INV_WIDTH:   cfg_r.inv_width   <= cfg_wdata[met_pkg::RECIP_W-1:0];
        met_pkg::REG_INV_HEIGHT:  cfg_r.inv_height  <= cfg_wdata[met_pkg::RECIP_W-1:0];
        met_pkg::REG_ASPECT:      cfg_r.aspect      <= cfg_wdata[met_pkg::RECIP_W-1:0];
        met_pkg::REG_MAX_ITER:    cfg_r.max_iter    <= cfg_wdata[met_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  met_seq #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_res (out_res),
    .cfg     (cfg_r),
    .mul_req (mul_req),
    .prod    (prod),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // shared multiplier
  met_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // shade divider
  met_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== bench/mandelbrot_escape_time_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_tb: self-checking bench for the escape-time engine
// A short scripted sequence of register writes and pixels (corners, centre,
// overflow, limits of three, zero and 65535) is followed by random viewports
// with random pixels. Every result word is checked, against a fixed value or a
// fixed-point model of the iteration kept in the bench, under bursty input and
// a stalling receiver.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top_tb;

  localparam int          COORD_BITS      = 12;
  localparam int          FRAC_BITS       = 28;
  localparam int          CNT_W           = met_pkg::CNT_W;
  localparam int          WORD_W          = met_pkg::WORD_W;
  localparam int          RECIP_W         = met_pkg::RECIP_W;
  localparam int          CFG_IDX_W       = met_pkg::CFG_IDX_W;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          PIXELS_PER_VIEW = 60;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam longint      HALF            = longint'(1) <<< (FRAC_BITS - 1);
  localparam longint      RADIUS_SQ       = longint'(4) <<< FRAC_BITS;
  localparam longint      WORD_HI         = (longint'(1) <<< 31) - 1;
  localparam longint      WORD_LO         = -(longint'(1) <<< 31);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      shade;
  } escape_result_t;

  typedef enum {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    met_pkg::cfg_reg_t     sel;
    logic [WORD_W-1:0]     data;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    bit                    fixed;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      shade;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  met_in_if  #(.COORD_BITS(COORD_BITS)) pix_if ();
  met_out_if #(.COORD_BITS(COORD_BITS)) res_if ();

  mandelbrot_escape_time_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // bench copy of the registers, results still owed by the engine
  met_pkg::cfg_t   view_regs;
  escape_result_t  expected_results[$];
  escape_result_t  oldest;
  int unsigned     mismatches = 0;
  int unsigned     elapsed_cycles = 0;
  int unsigned     burst_left = 0;
  logic [15:0]     stall_bits;
  int unsigned     stall_age;

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    elapsed_cycles <= elapsed_cycles + 1;
    if (elapsed_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic bit in_word_range(longint v);
    return v >= WORD_LO && v <= WORD_HI;
  endfunction

  // exact product rescaled, rounding towards minus infinity
  function automatic longint rescale_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // pixel index to one component of c; 0 when any stage leaves the word
  function automatic bit place_on_axis(input longint coord, input longint recip,
                                       input bit by_aspect, input longint shift,
                                       output longint pos);
    longint t;
    pos = 0;
    t = coord * recip;
    if (!in_word_range(t)) return 1'b0;
    if (by_aspect) begin
      t = rescale_mul(t, longint'(view_regs.aspect));
      if (!in_word_range(t)) return 1'b0;
    end
    t = t - HALF;
    if (!in_word_range(t)) return 1'b0;
    t = rescale_mul(t, longint'(signed'(view_regs.zoom_scale))) + shift;
    if (!in_word_range(t)) return 1'b0;
    pos = t;
    return 1'b1;
  endfunction

  function automatic escape_result_t predict_escape(logic [COORD_BITS-1:0] px,
                                                    logic [COORD_BITS-1:0] py);
    escape_result_t r;
    longint         cr, ci, zr, zi, nr, ni;
    int unsigned    step, iter_cap, hits;
    iter_cap = view_regs.max_iter;
    step = 0;
    hits = 0;
    if (place_on_axis(longint'(px), longint'(view_regs.inv_width), 1'b1,
                      longint'(signed'(view_regs.offset_real)), cr) &&
        place_on_axis(longint'(py), longint'(view_regs.inv_height), 1'b0,
                      longint'(signed'(view_regs.offset_imag)), ci)) begin
      zr = cr;
      zi = ci;
      for (step = 0; step < iter_cap; step++) begin
        nr = rescale_mul(zr, zr) - rescale_mul(zi, zi) + cr;
        ni = 2 * rescale_mul(zr, zi) + ci;
        // overflow of z counts as an escape at this update
        if (!in_word_range(nr) || !in_word_range(ni)) break;
        zr = nr;
        zi = ni;
        if (rescale_mul(zr, zr) + rescale_mul(zi, zi) > RADIUS_SQ) break;
      end
      hits = (step == iter_cap) ? 0 : step;
    end
    r.x     = px;
    r.y     = py;
    r.count = hits[CNT_W-1:0];
    r.shade = (iter_cap == 0) ? '0 : CNT_W'((longint'(hits) << 16) / iter_cap);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic directed_row_t pixel_row(logic [COORD_BITS-1:0] px,
                                              logic [COORD_BITS-1:0] py);
    return '{ROW_PIXEL, met_pkg::REG_ZOOM_SCALE, '0, px, py, 1'b0, '0, '0};
  endfunction

  function automatic directed_row_t pixel_known(logic [COORD_BITS-1:0] px,
                                                logic [COORD_BITS-1:0] py,
                                                logic [CNT_W-1:0] count,
                                                logic [CNT_W-1:0] shade);
    return '{ROW_PIXEL, met_pkg::REG_ZOOM_SCALE, '0, px, py, 1'b1, count, shade};
  endfunction

  function automatic directed_row_t reg_row(met_pkg::cfg_reg_t sel,
                                            logic [WORD_W-1:0] data);
    return '{ROW_REG, sel, data, '0, '0, 1'b0, '0, '0};
  endfunction

  // register write, then cfg_we dropped before the task returns
  task automatic write_reg(input met_pkg::cfg_reg_t sel, input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      met_pkg::REG_ZOOM_SCALE:  view_regs.zoom_scale  = data;
      met_pkg::REG_OFFSET_REAL: view_regs.offset_real = data;
      met_pkg::REG_OFFSET_IMAG: view_regs.offset_imag = data;
      met_pkg::REG_INV_WIDTH:   view_regs.inv_width   = data[RECIP_W-1:0];
      met_pkg::REG_INV_HEIGHT:  view_regs.inv_height  = data[RECIP_W-1:0];
      met_pkg::REG_ASPECT:      view_regs.aspect      = data[RECIP_W-1:0];
      met_pkg::REG_MAX_ITER:    view_regs.max_iter    = data[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold off the sender until every owed result has arrived
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // bursts of back-to-back words separated by random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_pixel(input logic [COORD_BITS-1:0] px,
                            input logic [COORD_BITS-1:0] py, input bit fixed,
                            input logic [CNT_W-1:0] count,
                            input logic [CNT_W-1:0] shade);
    escape_result_t want;
    pix_if.valid   <= 1'b1;
    pix_if.pixel_x <= px;
    pix_if.pixel_y <= py;
    do @(posedge clk); while (!pix_if.ready);
    if (fixed) want = '{px, py, count, shade};
    else want = predict_escape(px, py);
    expected_results.push_back(want);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_bits   <= 16'hFFFF;
      stall_age    <= 0;
    end else begin
      // compare each accepted word with the oldest prediction
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word x=%0d y=%0d arrived with no pixel owed",
                 res_if.out_x, res_if.out_y);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (res_if.out_x !== oldest.x) begin
            $error("out_x: expected %0d, got %0d", oldest.x, res_if.out_x);
            mismatches++;
          end
          if (res_if.out_y !== oldest.y) begin
            $error("out_y: expected %0d, got %0d", oldest.y, res_if.out_y);
            mismatches++;
          end
          if (res_if.escape_count !== oldest.count) begin
            $error("escape_count: expected %0d, got %0d", oldest.count,
                   res_if.escape_count);
            mismatches++;
          end
          if (res_if.shade !== oldest.shade) begin
            $error("shade: expected %0d, got %0d", oldest.shade, res_if.shade);
            mismatches++;
          end
        end
      end
      // stall pattern, renewed each time stall_age wraps
      res_if.ready <= stall_bits[stall_age[3:0]];
      if (stall_age == 47) begin
        stall_age <= 0;
        case ($urandom_range(0, 7))
          0, 1:    stall_bits <= 16'hFFFF;
          2:       stall_bits <= 16'h0000;
          default: stall_bits <= 16'($urandom);
        endcase
      end else begin
        stall_age <= stall_age + 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    directed_row_t     script[$];
    logic [WORD_W-1:0] reg_word [7];
    int unsigned       vp_w, vp_h;
    logic [COORD_BITS-1:0] px, py;

    pix_if.valid   <= 1'b0;
    pix_if.pixel_x <= '0;
    pix_if.pixel_y <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= met_pkg::REG_ZOOM_SCALE;
    cfg_wdata      <= '0;
    view_regs = met_pkg::CFG_RESET;

    script = '{
      // reset view: centre never escapes, far corner overflows on update 0
      pixel_known(12'd512, 12'd512, 16'd0, 16'd0),
      pixel_known(12'd4095, 12'd4095, 16'd0, 16'd0),
      pixel_row(12'd0, 12'd0),
      pixel_row(12'd0, 12'd4095),
      pixel_row(12'd4095, 12'd0),
      pixel_row(12'h555, 12'hAAA),
      pixel_row(12'hAAA, 12'h555),
      pixel_row(12'd800, 12'd512),
      pixel_row(12'd300, 12'd512),
      // short limit, junk above the 16 register bits
      reg_row(met_pkg::REG_MAX_ITER, 32'hABCD_0003),
      pixel_row(12'd1536, 12'd512),
      pixel_known(12'd512, 12'd512, 16'd0, 16'd0),
      // every register at an extreme: c overflows while being formed
      reg_row(met_pkg::REG_ZOOM_SCALE, 32'h7FFF_FFFF),
      reg_row(met_pkg::REG_OFFSET_REAL, 32'h8000_0000),
      reg_row(met_pkg::REG_OFFSET_IMAG, 32'h7FFF_FFFF),
      reg_row(met_pkg::REG_INV_WIDTH, 32'hFFFF_FFFF),
      reg_row(met_pkg::REG_INV_HEIGHT, 32'h0000_0000),
      reg_row(met_pkg::REG_ASPECT, 32'h7FFF_FFFF),
      reg_row(met_pkg::REG_MAX_ITER, 32'h0000_FFFF),
      pixel_row(12'd0, 12'd0),
      pixel_row(12'd1, 12'd4095),
      pixel_row(12'd4095, 12'd1),
      // limit of zero: no update runs
      reg_row(met_pkg::REG_MAX_ITER, 32'h5A5A_0000),
      pixel_known(12'd0, 12'd0, 16'd0, 16'd0),
      // default view with the longest limit
      reg_row(met_pkg::REG_ZOOM_SCALE, 32'h1000_0000),
      reg_row(met_pkg::REG_OFFSET_REAL, 32'h0000_0000),
      reg_row(met_pkg::REG_OFFSET_IMAG, 32'h0000_0000),
      reg_row(met_pkg::REG_INV_WIDTH, 32'h8004_0000),
      reg_row(met_pkg::REG_INV_HEIGHT, 32'h0004_0000),
      reg_row(met_pkg::REG_ASPECT, 32'h9000_0000),
      reg_row(met_pkg::REG_MAX_ITER, 32'hFFFF_FFFF),
      pixel_known(12'd512, 12'd512, 16'd0, 16'd0),
      pixel_row(12'd1024, 12'd512)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain_results();
        write_reg(script[i].sel, script[i].data);
      end else begin
        pace_sender();
        send_pixel(script[i].px, script[i].py, script[i].fixed, script[i].count,
                   script[i].shade);
      end
    end

    // random viewports, each loaded while the engine is empty
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      vp_w = $urandom_range(8, 600);
      vp_h = $urandom_range(8, 600);
      reg_word[met_pkg::REG_ZOOM_SCALE]  = $urandom_range(1 << 28, 3 << 28);
      if ($urandom_range(0, 3) == 0)
        reg_word[met_pkg::REG_ZOOM_SCALE] = -reg_word[met_pkg::REG_ZOOM_SCALE];
      reg_word[met_pkg::REG_OFFSET_REAL] = $urandom_range(0, 5 << 26) - (1 << 28);
      reg_word[met_pkg::REG_OFFSET_IMAG] = $urandom_range(0, 1 << 28) - (1 << 27);
      reg_word[met_pkg::REG_INV_WIDTH]   = {1'($urandom), RECIP_W'((1 << 28) / vp_w)};
      reg_word[met_pkg::REG_INV_HEIGHT]  = {1'($urandom), RECIP_W'((1 << 28) / vp_h)};
      reg_word[met_pkg::REG_ASPECT]      =
        {1'($urandom), RECIP_W'($urandom_range(3 << 26, 3 << 27))};
      reg_word[met_pkg::REG_MAX_ITER]    = {16'($urandom), 16'($urandom_range(2, 48))};
      case (ph)
        0: reg_word[met_pkg::REG_MAX_ITER][CNT_W-1:0] = 16'd1;
        1: reg_word[met_pkg::REG_MAX_ITER][CNT_W-1:0] = 16'd256;
        2: begin
          // raw register words, mostly overflow
          foreach (reg_word[r]) reg_word[r] = $urandom;
          reg_word[met_pkg::REG_MAX_ITER][CNT_W-1:0] = 16'($urandom_range(1, 40));
        end
        3: begin
          reg_word[met_pkg::REG_ZOOM_SCALE]  = 32'h8000_0000;
          reg_word[met_pkg::REG_OFFSET_REAL] = 32'h7FFF_FFFF;
          reg_word[met_pkg::REG_OFFSET_IMAG] = 32'h8000_0000;
          reg_word[met_pkg::REG_INV_HEIGHT]  = 32'hFFFF_FFFF;
          reg_word[met_pkg::REG_ASPECT]      = 32'h0000_0000;
        end
        default: ;
      endcase

      drain_results();
      write_reg(met_pkg::REG_ZOOM_SCALE, reg_word[met_pkg::REG_ZOOM_SCALE]);
      write_reg(met_pkg::REG_OFFSET_REAL, reg_word[met_pkg::REG_OFFSET_REAL]);
      write_reg(met_pkg::REG_OFFSET_IMAG, reg_word[met_pkg::REG_OFFSET_IMAG]);
      write_reg(met_pkg::REG_INV_WIDTH, reg_word[met_pkg::REG_INV_WIDTH]);
      write_reg(met_pkg::REG_INV_HEIGHT, reg_word[met_pkg::REG_INV_HEIGHT]);
      write_reg(met_pkg::REG_ASPECT, reg_word[met_pkg::REG_ASPECT]);
      write_reg(met_pkg::REG_MAX_ITER, reg_word[met_pkg::REG_MAX_ITER]);

      repeat (PIXELS_PER_VIEW) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        pace_sender();
        // mostly inside the viewport, some anywhere in the index range
        if (ph == 2 || $urandom_range(0, 6) == 0) begin
          px = COORD_BITS'($urandom);
          py = COORD_BITS'($urandom);
        end else begin
          px = COORD_BITS'($urandom_range(0, vp_w - 1));
          py = COORD_BITS'($urandom_range(0, vp_h - 1));
        end
        send_pixel(px, py, 1'b0, '0, '0);
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
